>>> hdl/plb_pkg.sv
// Shared constants and types for the price-level book.
package plb_pkg;
	localparam int LEVELS = 64;
	localparam logic [30:0] THRESH_RESET = 31'd1000;
	localparam logic [0:0] REG_THRESH = 1'b0;

	// one update as seen by a cell
	typedef struct packed {
		logic        del;
		logic [31:0] price;
		logic [30:0] qty;
	} upd_t;

	// per-cell status handed back to the control
	typedef struct packed {
		logic        valid;
		logic [31:0] price;
	} cell_st_t;
endpackage

>>> hdl/plb_cell.sv
// One sorted price-level cell; the chain keeps best at cell 0.
module plb_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op,
	input  plb_pkg::upd_t  upd,
	input  logic           match_here,
	input  logic           ins_here,
	input  logic           shift_dn,
	input  logic           shift_up,
	input  plb_pkg::cell_st_t prev_st,
	input  logic [30:0]    prev_qty,
	input  plb_pkg::cell_st_t next_st,
	input  logic [30:0]    next_qty,
	output plb_pkg::cell_st_t st,
	output logic [30:0]    qty
);
	import plb_pkg::*;
	logic        valid_q;
	logic [31:0] price_q;
	logic [30:0] qty_q;

	assign st.valid = valid_q;
	assign st.price = price_q;
	assign qty      = qty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			price_q <= '0;
			qty_q   <= '0;
		end else if (op) begin
			if (match_here && !upd.del) begin
				qty_q <= upd.qty;
			end else if (shift_up) begin
				valid_q <= next_st.valid;
				price_q <= next_st.price;
				qty_q   <= next_qty;
			end else if (ins_here) begin
				valid_q <= 1'b1;
				price_q <= upd.price;
				qty_q   <= upd.qty;
			end else if (shift_dn) begin
				valid_q <= prev_st.valid;
				price_q <= prev_st.price;
				qty_q   <= prev_qty;
			end
		end
	end
endmodule

>>> hdl/plb_side.sv
// One side of the book: a sorted chain of cells plus the search logic.
module plb_side (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           is_ask,
	input  logic           op,
	input  plb_pkg::upd_t  upd,
	output logic           found,
	output logic           full,
	output logic           empty,
	output logic [31:0]    best
);
	import plb_pkg::*;
	cell_st_t    st [LEVELS];
	logic [30:0] qv [LEVELS];
	logic [LEVELS-1:0] eq, past, mt, ins, sdn, sup;

	// past[i]: cell i is valid and better than the update (stays ahead)
	always_comb begin
		for (int i = 0; i < LEVELS; i++) begin
			eq[i] = st[i].valid && (st[i].price == upd.price);
			if (is_ask)
				past[i] = st[i].valid &&
					($signed(st[i].price) < $signed(upd.price));
			else
				past[i] = st[i].valid &&
					($signed(st[i].price) > $signed(upd.price));
		end
	end

	assign found = |eq;
	assign full  = st[LEVELS-1].valid;
	assign empty = !st[0].valid;
	assign best  = st[0].valid ? st[0].price : 32'd0;

	always_comb begin
		for (int i = 0; i < LEVELS; i++) begin
			mt[i]  = eq[i];
			ins[i] = !found && !upd.del && !past[i] && (i == 0 || past[i-1]);
			sdn[i] = !found && !upd.del && i != 0 && !past[i-1];
			// delete: the matched cell and the cells after it move up
			sup[i] = 1'b0;
			for (int j = 0; j < i + 1; j++)
				if (eq[j] && upd.del) sup[i] = 1'b1;
		end
	end

	for (genvar g = 0; g < LEVELS; g++) begin : g_cell
		plb_cell u_cell (
			.clk(clk), .arst_n(arst_n), .op(op), .upd(upd),
			.match_here(mt[g]), .ins_here(ins[g]), .shift_dn(sdn[g]),
			.shift_up(sup[g]),
			.prev_st(g == 0 ? st[0] : st[(g == 0) ? 0 : g-1]),
			.prev_qty(qv[(g == 0) ? 0 : g-1]),
			.next_st(g == LEVELS-1 ? '0 : st[(g == LEVELS-1) ? g : g+1]),
			.next_qty(qv[(g == LEVELS-1) ? g : g+1]),
			.st(st[g]), .qty(qv[g])
		);
	end
endmodule

>>> hdl/price_level_book_with_trigger_unit.sv
// Top level of the price-level book with order trigger.
// Usage:
//   s_axis_* carries one market update item; m_axis_* returns one result
//   item per update. size_threshold is written over the APB port at 0x0.
//   Each side is a chain of sorted cells with the best level in cell 0, so
//   the best price is read straight from the head cell.
// Timing:
//   An update is registered at its accepting edge. Once the output is free
//   (op), the cells search and compare, and they shift at the end of that
//   cycle while the order fields and pend_q are registered; pend_q sets
//   tvalid, with the best prices read from the head cells. An update is
//   taken only while the single input stage is empty, and that stage is
//   freed when the cells shift, before the previous result reaches tvalid.
// Stalls:
//   While a result waits in the output register a new update may be taken
//   into the input stage; it is applied only when the output is free.
// Reset:
//   arst_n clears both books, the order counter and sets the threshold to
//   1000.
module price_level_book_with_trigger_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: price[31:0], quantity[62:32], seq_in[93:63], pad to 96
	input  logic [95:0]  s_axis_tdata,
	// tuser: side_is_ask
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: fire, order_side_is_ask, order_price, order_seq_in,
	// order_seq_out, status, best_bid, best_ask, bid_empty, ask_empty,
	// pad to 168
	output logic [167:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import plb_pkg::*;
	logic [30:0] thresh_q;
	logic [31:0] cnt_q;
	logic        in_v_q, side_q;
	upd_t        upd_q;
	logic [30:0] seq_q;
	logic        out_v_q;
	logic [167:0] out_q;
	logic        op;
	logic        bf, bfull, be, af, afull, ae;
	logic [31:0] bb, ba;
	logic        found, full, empty, better, dropped, fire;
	logic [31:0] best;
	upd_t        ub, ua;
	logic        nb_e, na_e;
	logic [31:0] nb, na;

	assign pready = 1'b1;
	assign prdata = {1'b0, thresh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_THRESH
			&& paddr[1:0] == 2'b00) begin
			thresh_q <= pwdata[30:0];
		end
	end

	assign s_axis_tready = !in_v_q;
	assign op = in_v_q && (!out_v_q || m_axis_tready);

	assign found = side_q ? af : bf;
	assign full  = side_q ? afull : bfull;
	assign empty = side_q ? ae : be;
	assign best  = side_q ? ba : bb;
	assign better = empty || (side_q ? ($signed(upd_q.price) <= $signed(best))
		: ($signed(upd_q.price) >= $signed(best)));
	assign dropped = !upd_q.del && !found && full;
	assign fire = !upd_q.del && !dropped && better && (upd_q.qty > thresh_q);

	// a dropped or missing delete becomes no change
	always_comb begin
		ub = upd_q; ua = upd_q;
		ub.del = upd_q.del; ua.del = upd_q.del;
	end

	plb_side u_bid (.clk(clk), .arst_n(arst_n), .is_ask(1'b0),
		.op(op && !side_q && !dropped), .upd(ub),
		.found(bf), .full(bfull), .empty(be), .best(bb));
	plb_side u_ask (.clk(clk), .arst_n(arst_n), .is_ask(1'b1),
		.op(op && side_q && !dropped), .upd(ua),
		.found(af), .full(afull), .empty(ae), .best(ba));

	// best after the update, predicted from the head and second cells
	// is not available cheaply; results are read after the shift instead
	logic        pend_q;
	logic [97:0] pfx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_q  <= 1'b0;
			out_v_q <= 1'b0;
			pend_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				in_v_q <= 1'b1;
			end
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			pend_q <= op;
			if (op) begin
				in_v_q <= 1'b0;
				if (fire) cnt_q <= cnt_q + 32'd1;
			end
			if (pend_q) out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			side_q    <= s_axis_tuser;
			upd_q.price <= s_axis_tdata[31:0];
			upd_q.qty <= s_axis_tdata[62:32];
			upd_q.del <= s_axis_tdata[62:32] == 31'd0;
			seq_q     <= s_axis_tdata[93:63];
		end
		if (op) begin
			pfx_q <= {dropped, fire ? cnt_q : 32'd0, fire ? seq_q : 31'd0,
				fire ? upd_q.price : 32'd0, fire && side_q, fire};
		end
	end

	assign nb = bb; assign na = ba; assign nb_e = be; assign na_e = ae;
	assign out_q = {4'd0, na_e, nb_e, na, nb, pfx_q};
	assign m_axis_tdata  = out_q;
	assign m_axis_tvalid = out_v_q;
	// op is blocked while a stalled result waits so the output stays valid
endmodule

>>> hdl/plb_checker.sv
// Port-level checks for the price-level book, bound to the top level.
module plb_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [167:0] m_axis_tdata,
	input logic         pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_nofire: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[96:1] == '0)
		else $error("order fields set without fire");
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[97] |-> !m_axis_tdata[0])
		else $error("dropped update fired");
	a_rdy: assert property (@(posedge clk) pready)
		else $error("pready low");
endmodule

bind price_level_book_with_trigger_unit plb_checker u_chk (.*);

>>> sim/tb.sv
// Testbench for the price-level book with order trigger.
module tb;
	import plb_pkg::*;

	// one result item as the book should report it
	typedef struct {
		bit          fire;
		bit          order_side_is_ask;
		logic [31:0] order_price;
		logic [30:0] order_seq_in;
		logic [31:0] order_seq_out;
		bit          status;
		logic [31:0] best_bid;
		logic [31:0] best_ask;
		bit          bid_empty;
		bit          ask_empty;
	} book_result_t;

	localparam bit SIDE_BID = 1'b0;
	localparam bit SIDE_ASK = 1'b1;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// tdata: price[31:0], quantity[62:32], seq_in[93:63], zero pad to 96
	logic [95:0]  s_axis_tdata = '0;
	// tuser: side_is_ask
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// tdata: fire, order_side_is_ask, order_price, order_seq_in, order_seq_out,
	// status, best_bid, best_ask, bid_empty, ask_empty, zero pad to 168
	logic [167:0] m_axis_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	price_level_book_with_trigger_unit dut (.*);

	always #2 clk = ~clk;

	// shadow copy of the book
	logic signed [31:0] book_price [2][LEVELS];
	logic [30:0]        book_qty   [2][LEVELS];
	bit                 book_valid [2][LEVELS];
	logic [31:0]        orders_sent;
	logic [30:0]        threshold;

	book_result_t pending_results [$];
	bit           failed = 1'b0;
	int           holdoff_req = 0;  // receiver hold-off asked for, in cycles
	logic [30:0]  next_seq = '0;

	function automatic bit best_level(bit ask, output logic [31:0] best);
		bit found = 1'b0;
		best = '0;
		for (int i = 0; i < LEVELS; i++)
			if (book_valid[ask][i] && (!found ||
					(ask ? book_price[ask][i] < $signed(best)
					     : book_price[ask][i] > $signed(best)))) begin
				best = book_price[ask][i];
				found = 1'b1;
			end
		return found;
	endfunction

	function automatic int levels_held(bit ask);
		int n = 0;
		for (int i = 0; i < LEVELS; i++)
			n += book_valid[ask][i];
		return n;
	endfunction

	// applies one update to the shadow book and forms its result
	function automatic book_result_t apply_update(bit ask, logic [31:0] price,
			logic [30:0] qty, logic [30:0] seq);
		book_result_t r = '{default: '0};
		int hit = -1;
		int spare = -1;
		logic [31:0] best;
		bit held;
		for (int i = 0; i < LEVELS; i++) begin
			if (book_valid[ask][i]) begin
				if (hit < 0 && book_price[ask][i] == $signed(price))
					hit = i;
			end else if (spare < 0) begin
				spare = i;
			end
		end
		if (qty == 0) begin
			if (hit >= 0)
				book_valid[ask][hit] = 1'b0;
		end else if (hit < 0 && spare < 0) begin
			r.status = 1'b1;
		end else begin
			held = best_level(ask, best);
			if (qty > threshold && (!held || (ask ? $signed(price) <= $signed(best)
					: $signed(price) >= $signed(best)))) begin
				r.fire = 1'b1;
				r.order_side_is_ask = ask;
				r.order_price = price;
				r.order_seq_in = seq;
				r.order_seq_out = orders_sent;
				orders_sent++;
			end
			if (hit < 0)
				hit = spare;
			book_price[ask][hit] = price;
			book_qty[ask][hit] = qty;
			book_valid[ask][hit] = 1'b1;
		end
		r.bid_empty = !best_level(SIDE_BID, r.best_bid);
		r.ask_empty = !best_level(SIDE_ASK, r.best_ask);
		return r;
	endfunction

	// sender: random gap, then offer until accepted; valid stays high after
	// acceptance so back-to-back items never toggle it within one step
	task automatic send_update(bit ask, logic [31:0] price, logic [30:0] qty);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 :
			(($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2));
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= ask;
		s_axis_tdata <= {2'b00, next_seq, qty, price};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(apply_update(ask, price, qty, next_seq));
		next_seq = 31'($urandom());
		@(negedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// APB write: setup then access; register takes it at the access edge
	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		settle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr == 3'd4 * REG_THRESH)
			threshold = value[30:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// receiver: random stalls, plus a long hold-off counted here on request
	always @(negedge clk) begin
		if (holdoff_req > 0) begin
			m_axis_tready <= 1'b0;
			holdoff_req <= holdoff_req - 1;
		end else if ($urandom_range(0, 19) == 0)
			m_axis_tready <= 1'b0;
		else if ($urandom_range(0, 2) == 0)
			m_axis_tready <= $urandom_range(0, 1);
		else
			m_axis_tready <= 1'b1;
	end

	// result checker
	always @(posedge clk) begin
		book_result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected");
				failed = 1'b1;
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tdata[0] !== e.fire) begin
					$error("fire: expected %0d, got %0d", e.fire, m_axis_tdata[0]);
					failed = 1'b1;
				end
				if (m_axis_tdata[1] !== e.order_side_is_ask) begin
					$error("order_side_is_ask: expected %0d, got %0d",
						e.order_side_is_ask, m_axis_tdata[1]);
					failed = 1'b1;
				end
				if (m_axis_tdata[33:2] !== e.order_price) begin
					$error("order_price: expected %0d, got %0d",
						$signed(e.order_price), $signed(m_axis_tdata[33:2]));
					failed = 1'b1;
				end
				if (m_axis_tdata[64:34] !== e.order_seq_in) begin
					$error("order_seq_in: expected %0d, got %0d",
						e.order_seq_in, m_axis_tdata[64:34]);
					failed = 1'b1;
				end
				if (m_axis_tdata[96:65] !== e.order_seq_out) begin
					$error("order_seq_out: expected %0d, got %0d",
						e.order_seq_out, m_axis_tdata[96:65]);
					failed = 1'b1;
				end
				if (m_axis_tdata[97] !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, m_axis_tdata[97]);
					failed = 1'b1;
				end
				if (m_axis_tdata[129:98] !== e.best_bid) begin
					$error("best_bid: expected %0d, got %0d",
						$signed(e.best_bid), $signed(m_axis_tdata[129:98]));
					failed = 1'b1;
				end
				if (m_axis_tdata[161:130] !== e.best_ask) begin
					$error("best_ask: expected %0d, got %0d",
						$signed(e.best_ask), $signed(m_axis_tdata[161:130]));
					failed = 1'b1;
				end
				if (m_axis_tdata[162] !== e.bid_empty) begin
					$error("bid_empty: expected %0d, got %0d", e.bid_empty, m_axis_tdata[162]);
					failed = 1'b1;
				end
				if (m_axis_tdata[163] !== e.ask_empty) begin
					$error("ask_empty: expected %0d, got %0d", e.ask_empty, m_axis_tdata[163]);
					failed = 1'b1;
				end
			end
		end
	end

	// directed: extremes, empty sides, deletes (missing and present), ties
	task automatic test_directed();
		send_update(SIDE_BID, 32'sd100, 31'd5);            // empty side, below threshold
		send_update(SIDE_BID, 32'sd100, 31'd0);            // delete present level
		send_update(SIDE_BID, 32'sd100, 31'd0);            // delete missing level
		send_update(SIDE_ASK, 32'sd200, 31'd1001);         // empty side fires
		send_update(SIDE_ASK, 32'sd200, 31'd1000);         // at threshold, no fire
		send_update(SIDE_ASK, 32'sd200, 31'h7FFF_FFFF);    // tie at best fires
		send_update(SIDE_ASK, 32'sd250, 31'd5000);         // worse ask, no fire
		send_update(SIDE_ASK, 32'sd150, 31'd5000);         // better ask fires
		send_update(SIDE_BID, 32'h8000_0000, 31'd2000);    // most negative price
		send_update(SIDE_BID, 32'h7FFF_FFFF, 31'd2000);    // most positive, fires
		send_update(SIDE_BID, 32'h8000_0000, 31'd3000);    // worse bid, no fire
		send_update(SIDE_BID, 32'shFFFF_FFFF, 31'd1);
		send_update(SIDE_ASK, 32'h8000_0000, 31'd2000);
		send_update(SIDE_ASK, 32'h7FFF_FFFF, 31'd0);       // delete missing
		send_update(SIDE_BID, 32'h7FFF_FFFF, 31'd0);       // delete best bid
		send_update(SIDE_ASK, 32'h8000_0000, 31'd0);
		send_update(SIDE_BID, 32'h8000_0000, 31'd0);
		send_update(SIDE_BID, 32'shFFFF_FFFF, 31'd0);
		send_update(SIDE_ASK, 32'sd150, 31'd0);
		send_update(SIDE_ASK, 32'sd200, 31'd0);
		send_update(SIDE_ASK, 32'sd250, 31'd0);            // both sides empty again
	endtask

	// fill the ask side, then a dropped insert and an overwrite while full
	task automatic test_table_full();
		int k = 0;
		while (levels_held(SIDE_ASK) < LEVELS) begin
			send_update(SIDE_ASK, 32'sd1000000 + k, 31'($urandom_range(1, 3000)));
			k++;
		end
		send_update(SIDE_ASK, 32'sd500, 31'd9999);         // dropped, flagged
		send_update(SIDE_ASK, 32'sd1000000, 31'd9999);     // overwrite still works
		send_update(SIDE_ASK, 32'sd1000000, 31'd0);
		send_update(SIDE_ASK, 32'sd500, 31'd9999);         // room again
		for (int i = 0; i < LEVELS; i++)
			if (book_valid[SIDE_ASK][i])
				send_update(SIDE_ASK, book_price[SIDE_ASK][i], 31'd0);
	endtask

	// random market traffic: a narrow price band per side so levels are hit
	// again, with now and then a price or quantity anywhere in range
	task automatic test_random(int n);
		bit ask;
		logic [31:0] price;
		logic [30:0] qty;
		for (int i = 0; i < n; i++) begin
			ask = $urandom_range(0, 1);
			if ($urandom_range(0, 15) == 0)
				price = $urandom();
			else
				price = (ask ? 32'sd5000 : 32'sd4980) + $urandom_range(0, 40) - 20;
			case ($urandom_range(0, 9))
				0, 1, 2: qty = '0;
				3:       qty = 31'($urandom());
				4:       qty = 31'(threshold + $urandom_range(0, 2) - 1);
				default: qty = 31'($urandom_range(1, 2 * (threshold % 5000) + 2));
			endcase
			send_update(ask, price, qty);
		end
	endtask

	// long receiver hold-off while updates keep coming: block must back up
	task automatic test_backpressure();
		settle();
		holdoff_req = 80;
		test_random(12);
	endtask

	initial begin : limit
		#4000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		orders_sent = '0;
		threshold = THRESH_RESET;
		foreach (book_valid[s, i])
			book_valid[s][i] = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_table_full();
		test_random(50);
		test_backpressure();
		write_reg(3'd4, $urandom());                       // not a register, ignored
		test_random(60);
		write_reg(3'd4 * REG_THRESH, 32'd0);               // any nonzero quantity may fire
		test_random(80);
		write_reg(3'd4 * REG_THRESH, 32'hFFFF_FFFF);       // masked to 31 bits: never fires
		test_random(60);
		write_reg(3'd4 * REG_THRESH, $urandom_range(1, 4000));
		test_random(90);
		settle();

		if (!failed)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
